[hdl/ssph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum smoothing and peak hold package
// Shared types, register indexes, reset values and item codes.
// ----------------------------------------------------------------------------
package ssph_pkg;

  // Default geometry of the bin store.
  localparam int NUM_BINS_DEF     = 2048;
  localparam int NUM_CHANNELS_DEF = 2;

  // Payload widths fixed by the item format.
  localparam int BIN_W  = 11;
  localparam int LVL_W  = 16;
  localparam int HOLD_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FREEZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd4;

  // Register values after reset.
  localparam logic        FREEZE_RST = 1'b0;
  localparam logic [15:0] WEIGHT_RST = 16'd42598;
  localparam logic [14:0] DECAY_RST  = 15'd90;
  localparam logic [7:0]  HOLD_RST   = 8'd30;
  localparam logic [14:0] FLOOR_RST  = 15'd23040;

  // Item action codes.
  localparam logic ACT_UPDATE     = 1'b0;
  localparam logic ACT_RESET_PEAK = 1'b1;

  // One word of the bin store.
  typedef struct packed {
    logic                    seen;
    logic [HOLD_W-1:0]       hold;
    logic signed [LVL_W-1:0] peak;
    logic signed [LVL_W-1:0] smooth;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic                    channel;
    logic [BIN_W-1:0]        bin;
    logic signed [LVL_W-1:0] smoothed;
    logic signed [LVL_W-1:0] peak;
  } result_t;

endpackage
`default_nettype wire

[hdl/ssph_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum smoothing and peak hold channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ssph_in_if;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic                    channel;
  logic [10:0]             bin;
  logic signed [15:0]      magnitude;

  modport source (output valid, action, channel, bin, magnitude, input ready);
  modport sink   (input valid, action, channel, bin, magnitude, output ready);
endinterface

interface ssph_out_if;
  logic                    valid;
  logic                    ready;
  logic                    out_channel;
  logic [10:0]             out_bin;
  logic signed [15:0]      smoothed;
  logic signed [15:0]      peak;

  modport source (output valid, out_channel, out_bin, smoothed, peak, input ready);
  modport sink   (input valid, out_channel, out_bin, smoothed, peak, output ready);
endinterface

interface ssph_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              index;
  logic [15:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/ssph_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, and a read that returns the old word on a same-edge write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/spectrum_smoothing_peak_hold.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spectrum smoothing and peak hold
// Per-bin one-pole smoothing and a peak trace with hold and decay, for up to
// two channels of spectrum bins.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_ch: a magnitude update or a peak reset for one channel
// and bin. Every accepted item gives exactly one beat on out_ch with the
// channel, the bin and the stored smoothed and peak levels after the item.
// Registers are written on cfg_ch, which is always ready; write them only
// while no item is in flight.
// The result beat passes the item stage and then the result queue before it
// is valid on out_ch. One item is accepted every cycle while in_ch.ready is
// high: the bin store is read in the accept cycle and written back in the
// next cycle, and a write to the same entry in the cycle of the read is
// forwarded, so the same bin may repeat back to back.
// After reset the block sweeps the bin store to clear each entry's seen
// flag, one entry per cycle, over all NUM_CHANNELS * NUM_BINS entries
// (4096 by default); in_ch.ready stays low meanwhile.
// When out_ch stalls, results collect in a three-entry queue and in_ch.ready
// drops once the queue and the item in flight would fill it.
// ----------------------------------------------------------------------------
module spectrum_smoothing_peak_hold #(
  parameter int NUM_BINS     = ssph_pkg::NUM_BINS_DEF,
  parameter int NUM_CHANNELS = ssph_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ssph_in_if.sink   in_ch,
  ssph_out_if.source out_ch,
  ssph_cfg_if.sink  cfg_ch
);

  localparam int DEPTH  = NUM_CHANNELS * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = $bits(ssph_pkg::entry_t);

  // Configuration registers.
  logic        freeze_r;
  logic [15:0] weight_r;
  logic [14:0] decay_r;
  logic [7:0]  hold_upd_r;
  logic [14:0] floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freeze_r   <= ssph_pkg::FREEZE_RST;
      weight_r   <= ssph_pkg::WEIGHT_RST;
      decay_r    <= ssph_pkg::DECAY_RST;
      hold_upd_r <= ssph_pkg::HOLD_RST;
      floor_r    <= ssph_pkg::FLOOR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ssph_pkg::REG_FREEZE: freeze_r   <= cfg_ch.data[0];
        ssph_pkg::REG_WEIGHT: weight_r   <= cfg_ch.data;
        ssph_pkg::REG_DECAY:  decay_r    <= cfg_ch.data[14:0];
        ssph_pkg::REG_HOLD:   hold_upd_r <= cfg_ch.data[7:0];
        ssph_pkg::REG_FLOOR:  floor_r    <= cfg_ch.data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Clearing sweep of the bin store after reset.
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Input acceptance and store address.
  logic              in_fire;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  logic [1:0]        q_cnt_r;
  logic              s1_v_r;

  assign in_ch.ready = !clr_busy_r && (({1'b0, q_cnt_r} + {2'b00, s1_v_r}) < 3'd3);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = (32'(in_ch.channel) < 32'(NUM_CHANNELS)) &&
                       (32'(in_ch.bin) < 32'(NUM_BINS));
  assign in_addr     = ADDR_W'((in_ch.channel ? 32'(NUM_BINS) : 32'd0) + 32'(in_ch.bin));

  // Item stage that meets the read data.
  logic               s1_action_r;
  logic               s1_chan_r;
  logic [10:0]        s1_bin_r;
  logic signed [15:0] s1_mag_r;
  logic               s1_range_r;
  logic [ADDR_W-1:0]  s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
    end
    if (in_fire) begin
      s1_action_r <= in_ch.action;
      s1_chan_r   <= in_ch.channel;
      s1_bin_r    <= in_ch.bin;
      s1_mag_r    <= in_ch.magnitude;
      s1_range_r  <= in_range;
      s1_addr_r   <= in_addr;
    end
  end

  // Bin store.
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  ssph_pkg::entry_t     clr_word;
  ssph_pkg::entry_t     upd_word;
  logic                 upd_we;

  assign clr_word  = '{seen: 1'b0, hold: '0, peak: '0, smooth: '0};
  assign ram_we    = clr_busy_r || upd_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? ENT_W'(clr_word) : ENT_W'(upd_word);

  ssph_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Forwarding of the write that lands on the same edge as the read.
  logic              fwd_v_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [ENT_W-1:0]  fwd_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= ram_we;
    end
    fwd_addr_r <= ram_waddr;
    fwd_word_r <= ram_wdata;
  end

  // Read-modify-write of the entry.
  ssph_pkg::entry_t   old_word;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [34:0] acc;
  logic signed [15:0] smooth_calc;
  logic signed [15:0] base_s;
  logic signed [15:0] base_p;
  logic [7:0]         base_h;
  logic signed [16:0] decayed;
  logic signed [15:0] peak_reset;
  ssph_pkg::result_t  res;

  always_comb begin
    old_word = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? ssph_pkg::entry_t'(fwd_word_r)
                                                       : ssph_pkg::entry_t'(ram_rdata);

    // new = in + w * (old - in), rounded half up.
    diff        = {old_word.smooth[15], old_word.smooth} - {s1_mag_r[15], s1_mag_r};
    prod        = diff * $signed({1'b0, weight_r});
    acc         = {{3{s1_mag_r[15]}}, s1_mag_r, 16'h0000} + {prod[33], prod} + 35'sd32768;
    smooth_calc = acc[31:16];

    // A first update loads the magnitude and an empty hold.
    if (old_word.seen) begin
      base_s = smooth_calc;
      base_p = old_word.peak;
      base_h = old_word.hold;
    end else begin
      base_s = s1_mag_r;
      base_p = s1_mag_r;
      base_h = '0;
    end

    decayed    = {base_p[15], base_p} - {2'b00, decay_r};
    peak_reset = 16'(17'd0 - {2'b00, floor_r});

    upd_word        = old_word;
    upd_we          = 1'b0;
    res.channel     = s1_chan_r;
    res.bin         = s1_bin_r;
    res.smoothed    = '0;
    res.peak        = '0;

    if (s1_range_r) begin
      if (s1_action_r == ssph_pkg::ACT_RESET_PEAK) begin
        // Peak reset keeps the hold count and the seen flag.
        upd_word.peak = peak_reset;
        upd_we        = s1_v_r;
        res.peak      = peak_reset;
        if (old_word.seen) begin
          res.smoothed = old_word.smooth;
        end
      end else if (freeze_r) begin
        if (old_word.seen) begin
          res.smoothed = old_word.smooth;
          res.peak     = old_word.peak;
        end
      end else begin
        // Peak rule: rise and reload, else count the hold down, else decay.
        upd_word.seen   = 1'b1;
        upd_word.smooth = base_s;
        if (base_s > base_p) begin
          upd_word.peak = base_s;
          upd_word.hold = hold_upd_r;
        end else if (base_h != 8'd0) begin
          upd_word.peak = base_p;
          upd_word.hold = base_h - 8'd1;
        end else begin
          upd_word.hold = base_h;
          upd_word.peak = (decayed < -17'sd32768) ? -16'sd32768 : decayed[15:0];
        end
        upd_we       = s1_v_r;
        res.smoothed = upd_word.smooth;
        res.peak     = upd_word.peak;
      end
    end
  end

  // Result queue of three beats.
  ssph_pkg::result_t q_r [3];
  logic [1:0]        q_wr_r;
  logic [1:0]        q_rd_r;
  logic              out_fire;

  assign out_fire = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
    end else begin
      if (s1_v_r) begin
        q_wr_r <= (q_wr_r == 2'd2) ? 2'd0 : q_wr_r + 2'd1;
      end
      if (out_fire) begin
        q_rd_r <= (q_rd_r == 2'd2) ? 2'd0 : q_rd_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + {1'b0, s1_v_r} - {1'b0, out_fire};
    end
    if (s1_v_r) begin
      q_r[q_wr_r] <= res;
    end
  end

  assign out_ch.valid       = (q_cnt_r != 2'd0);
  assign out_ch.out_channel = q_r[q_rd_r].channel;
  assign out_ch.out_bin     = q_r[q_rd_r].bin;
  assign out_ch.smoothed    = q_r[q_rd_r].smoothed;
  assign out_ch.peak        = q_r[q_rd_r].peak;

endmodule
`default_nettype wire

[tb/tb_spectrum_smoothing_peak_hold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum smoothing and peak hold testbench
// Sends update and peak reset beats through the block under several register
// settings, with random gaps on both sides and one long result stall. Every
// result beat is checked field by field against a scoreboard that tracks the
// per-bin smoothed level, peak trace, hold counter and seen flag.
// ----------------------------------------------------------------------------
package ssph_tb_pkg;
  import ssph_pkg::*;

  localparam int NUM_ENTRIES = NUM_CHANNELS_DEF * NUM_BINS_DEF;
  localparam logic signed [LVL_W-1:0] LEVEL_MIN = 16'sh8000;

  // One input beat as the sender builds it.
  typedef struct {
    logic                    action;
    logic                    channel;
    logic [BIN_W-1:0]        bin;
    logic signed [LVL_W-1:0] magnitude;
  } level_item_t;

  // One full register setting.
  typedef struct {
    logic        freeze;
    logic [15:0] weight;
    logic [14:0] decay;
    logic [7:0]  hold;
    logic [14:0] floor_level;
  } reg_set_t;

  class level_scoreboard;
    // Register copies.
    logic        freeze;
    logic [15:0] weight;
    logic [14:0] decay;
    logic [7:0]  hold_reload;
    logic [14:0] floor_level;

    // Per-entry state, indexed by channel and bin.
    logic signed [LVL_W-1:0] smooth_mem [NUM_ENTRIES];
    logic signed [LVL_W-1:0] peak_mem [NUM_ENTRIES];
    logic [HOLD_W-1:0]       hold_mem [NUM_ENTRIES];
    logic                    seen_mem [NUM_ENTRIES];

    // Levels still owed by the block, oldest first.
    result_t pending_levels [$];

    int errors    = 0;
    int n_items   = 0;
    int n_resets  = 0;
    int n_frozen  = 0;
    int n_checked = 0;

    function new();
      freeze      = FREEZE_RST;
      weight      = WEIGHT_RST;
      decay       = DECAY_RST;
      hold_reload = HOLD_RST;
      floor_level = FLOOR_RST;
      foreach (seen_mem[k]) seen_mem[k] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FREEZE: freeze = data[0];
        REG_WEIGHT: weight = data;
        REG_DECAY:  decay = data[14:0];
        REG_HOLD:   hold_reload = data[7:0];
        REG_FLOOR:  floor_level = data[14:0];
        default: ;
      endcase
    endfunction

    // One-pole filter, rounded half up: w*old + (1-w)*in in Q0.16.
    function logic signed [LVL_W-1:0] smooth_next(logic signed [LVL_W-1:0] prev,
                                                 logic signed [LVL_W-1:0] mag);
      longint acc;
      longint shifted;
      acc = longint'(weight) * longint'(prev)
          + (longint'(65536) - longint'(weight)) * longint'(mag) + longint'(32768);
      shifted = acc >>> 16;
      return shifted[LVL_W-1:0];
    endfunction

    // Peak follows a rise and reloads the hold, else holds, else decays.
    function void follow_peak(int idx);
      int lowered;
      if (smooth_mem[idx] > peak_mem[idx]) begin
        peak_mem[idx] = smooth_mem[idx];
        hold_mem[idx] = hold_reload;
      end else if (hold_mem[idx] != 0) begin
        hold_mem[idx] = hold_mem[idx] - 1'b1;
      end else begin
        lowered = int'(peak_mem[idx]) - int'(decay);
        peak_mem[idx] = (lowered < -32768) ? LEVEL_MIN : lowered[LVL_W-1:0];
      end
    endfunction

    // Apply an accepted beat and queue the levels it must report.
    function void note_item(level_item_t it);
      int      idx;
      result_t want;
      idx = {it.channel, it.bin};
      want.channel  = it.channel;
      want.bin      = it.bin;
      want.smoothed = '0;
      want.peak     = '0;
      n_items++;
      if (it.action == ACT_RESET_PEAK) begin
        n_resets++;
        peak_mem[idx] = -$signed({1'b0, floor_level});
        want.peak = peak_mem[idx];
        if (seen_mem[idx]) want.smoothed = smooth_mem[idx];
      end else begin
        if (freeze) begin
          n_frozen++;
        end else begin
          // A bin's first update loads the input before the peak rule runs.
          if (!seen_mem[idx]) begin
            smooth_mem[idx] = it.magnitude;
            peak_mem[idx]   = it.magnitude;
            hold_mem[idx]   = '0;
            seen_mem[idx]   = 1'b1;
          end else begin
            smooth_mem[idx] = smooth_next(smooth_mem[idx], it.magnitude);
          end
          follow_peak(idx);
        end
        if (seen_mem[idx]) begin
          want.smoothed = smooth_mem[idx];
          want.peak     = peak_mem[idx];
        end
      end
      pending_levels = {pending_levels, want};
    endfunction

    task report(string what, int want, int got);
      $display("[%0t] mismatch: %s, expected %0d, got %0d", $time, what, want, got);
      errors++;
    endtask

    task check_levels(result_t got);
      result_t want;
      if (pending_levels.size() == 0) begin
        report($sformatf("unexpected beat for bin %0d", got.bin), -1, got.bin);
        return;
      end
      want = pending_levels[0];
      pending_levels.delete(0);
      n_checked++;
      if (got.channel !== want.channel)
        report("channel", want.channel, got.channel);
      if (got.bin !== want.bin)
        report("bin", want.bin, got.bin);
      if (got.smoothed !== want.smoothed)
        report($sformatf("smoothed of bin %0d", want.bin), want.smoothed, got.smoothed);
      if (got.peak !== want.peak)
        report($sformatf("peak of bin %0d", want.bin), want.peak, got.peak);
    endtask

    task report_leftovers();
      result_t want;
      while (pending_levels.size() != 0) begin
        want = pending_levels[0];
        pending_levels.delete(0);
        report($sformatf("missing beat for channel %0d", want.channel), want.bin, -1);
      end
    endtask
  endclass

endpackage

module tb_spectrum_smoothing_peak_hold;
  import ssph_pkg::*;
  import ssph_tb_pkg::*;

  localparam int DRAIN_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 346;
  localparam int FROZEN_ITEMS    = 100;
  localparam int TIMEOUT_NS      = 1_000_000;

  localparam logic signed [LVL_W-1:0] MAG_MAX  = 16'sh7fff;
  localparam logic signed [LVL_W-1:0] MAG_MIN  = 16'sh8000;
  localparam logic [BIN_W-1:0]        BIN_LAST = 11'd2047;

  logic clk;
  logic rst_n;

  ssph_in_if  in_ch ();
  ssph_out_if out_ch ();
  ssph_cfg_if cfg_ch ();

  spectrum_smoothing_peak_hold u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  level_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_asked = 0;
  int hold_off_done  = 0;
  int hold_off_left  = 0;
  int held_in_cycles = 0;
  int settings_used  = 1;

  // Bins that most random beats hit, so hold and decay get exercised.
  logic [11:0] hot_bins [8];
  int          level_base;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic level_item_t make_item(logic act, logic ch, logic [BIN_W-1:0] bin,
                                            logic signed [LVL_W-1:0] mag);
    level_item_t it;
    it.action    = act;
    it.channel   = ch;
    it.bin       = bin;
    it.magnitude = mag;
    return it;
  endfunction

  // Mostly hot bins; magnitudes full range, near a phase level, or extreme.
  function automatic level_item_t random_item();
    level_item_t it;
    logic [11:0] where;
    int          roll;
    it.action = ($urandom_range(99) < 8) ? ACT_RESET_PEAK : ACT_UPDATE;
    where = ($urandom_range(99) < 70) ? hot_bins[$urandom_range(7)] : 12'($urandom);
    it.channel = where[11];
    it.bin     = where[10:0];
    roll = $urandom_range(99);
    if (roll < 55)
      it.magnitude = 16'($urandom);
    else if (roll < 90)
      it.magnitude = 16'(level_base + int'($urandom_range(0, 1536)) - 768);
    else
      it.magnitude = $urandom_range(1) ? MAG_MAX : MAG_MIN;
    return it;
  endfunction

  // Zero or the top value a fifth of the time each, else a usual value.
  function automatic int pick_value(int top, int usual);
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 0;
    if (roll < 40) return top;
    return $urandom_range(0, usual);
  endfunction

  // Offer one beat, after random idle cycles, and hold it until accepted.
  task automatic send_item(input level_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.channel   <= it.channel;
    in_ch.bin       <= it.bin;
    in_ch.magnitude <= it.magnitude;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Stop offering and wait until every owed beat has come back.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (sb.pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; unused upper bits carry noise.
  task automatic program_regs(input reg_set_t r);
    logic [CFG_DATA_W-1:0] val [5];
    val[REG_FREEZE] = {15'($urandom), r.freeze};
    val[REG_WEIGHT] = r.weight;
    val[REG_DECAY]  = {1'($urandom), r.decay};
    val[REG_HOLD]   = {8'($urandom), r.hold};
    val[REG_FLOOR]  = {1'($urandom), r.floor_level};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(k);
      cfg_ch.data  <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.write_reg(CFG_IDX_W'(k), val[k]);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: check each beat, then pick the next ready value.
  initial begin : receive_results
    result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.channel  = out_ch.out_channel;
        got.bin      = out_ch.out_bin;
        got.smoothed = out_ch.smoothed;
        got.peak     = out_ch.peak;
        sb.check_levels(got);
      end
      if (hold_off_left > 0 && in_ch.valid && !in_ch.ready) held_in_cycles++;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_off_done != hold_off_asked) begin
        hold_off_done++;
        hold_off_left = HOLD_OFF_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus.
  initial begin : run_stimulus
    reg_set_t cfg;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_UPDATE;
    in_ch.channel    = 1'b0;
    in_ch.bin        = '0;
    in_ch.magnitude  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_FREEZE;
    cfg_ch.data      = '0;
    send_idle_pct    = 20;
    recv_idle_pct    = 55;
    level_base       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first load, repeat on the same bin, fall, peak reset,
    // and a peak reset on a bin that has never been updated.
    send_item(make_item(ACT_UPDATE, 1'b0, '0, MAG_MAX));
    send_item(make_item(ACT_UPDATE, 1'b0, '0, MAG_MAX));
    send_item(make_item(ACT_UPDATE, 1'b0, '0, MAG_MIN));
    send_item(make_item(ACT_RESET_PEAK, 1'b0, '0, '0));
    send_item(make_item(ACT_UPDATE, 1'b1, BIN_LAST, MAG_MIN));
    send_item(make_item(ACT_RESET_PEAK, 1'b1, BIN_LAST - 1'b1, MAG_MAX));
    send_item(make_item(ACT_UPDATE, 1'b1, BIN_LAST - 1'b1, 16'sh1234));
    drain_results();

    // No smoothing, no hold, largest decay: saturation at the bottom.
    cfg = '{1'b0, 16'd0, 15'h7fff, 8'd0, 15'h7fff};
    program_regs(cfg);
    send_item(make_item(ACT_UPDATE, 1'b0, 11'd5, MAG_MIN));
    send_item(make_item(ACT_UPDATE, 1'b0, 11'd5, 16'sd100));
    send_item(make_item(ACT_UPDATE, 1'b0, 11'd5, 16'sd100));
    send_item(make_item(ACT_UPDATE, 1'b0, 11'd5, 16'sd100));
    send_item(make_item(ACT_RESET_PEAK, 1'b0, 11'd5, '0));
    send_item(make_item(ACT_UPDATE, 1'b1, 11'd1024, 16'sh5555));
    send_item(make_item(ACT_UPDATE, 1'b1, 11'd1024, 16'shaaaa));
    drain_results();

    // Heaviest smoothing, no decay, longest hold, zero floor.
    cfg = '{1'b0, 16'hffff, 15'd0, 8'hff, 15'd0};
    program_regs(cfg);
    send_item(make_item(ACT_UPDATE, 1'b0, '0, MAG_MAX));
    send_item(make_item(ACT_RESET_PEAK, 1'b0, '0, '0));
    send_item(make_item(ACT_UPDATE, 1'b0, '0, MAG_MIN));
    drain_results();

    // Frozen: updates change nothing, peak resets still act.
    cfg.freeze = 1'b1;
    program_regs(cfg);
    send_item(make_item(ACT_UPDATE, 1'b0, '0, '0));
    send_item(make_item(ACT_UPDATE, 1'b1, 11'd3, MAG_MAX));
    send_item(make_item(ACT_RESET_PEAK, 1'b0, '0, '0));
    send_item(make_item(ACT_RESET_PEAK, 1'b1, 11'd4, MAG_MIN));
    drain_results();

    // Random phases: the receiver idles more first, then the sender, then
    // neither; one phase is frozen and one has a long result stall.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 55;
        recv_idle_pct = 20;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg.freeze      = (ph == 3);
      cfg.weight      = 16'(pick_value(65535, 65535));
      cfg.decay       = 15'(pick_value(32767, 600));
      cfg.hold        = 8'(pick_value(255, 12));
      cfg.floor_level = 15'(pick_value(32767, 32767));
      program_regs(cfg);
      foreach (hot_bins[k]) hot_bins[k] = 12'($urandom);
      level_base = int'($urandom_range(0, 40000)) - 20000;
      if (ph == 4) hold_off_asked++;
      repeat ((ph == 3) ? FROZEN_ITEMS : PHASE_ITEMS) send_item(random_item());
      drain_results();
    end

    sb.report_leftovers();
    $display("Run covered %0d beats (%0d peak resets, %0d frozen updates) over %0d settings.",
             sb.n_items, sb.n_resets, sb.n_frozen, settings_used);
    $display("%0d results checked; input held back %0d cycles during the result stall.",
             sb.n_checked, held_in_cycles);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Timed out with %0d results outstanding.", sb.pending_levels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
